[design/pnsh_pkg.sv]
// ----------------------------------------------------------------------------
// pnsh_pkg
// Shared types, constants and the saturation helper for the planar shadow
// matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none

package pnsh_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int WIDE = 68;
  localparam logic [1:0] LAST_COL = 2'd3;

  localparam logic signed [WIDE-1:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [WIDE-1:0] SAT_MIN = -68'sd2147483648;

  typedef logic signed [WIDE-1:0] wide_t;

  typedef struct packed {
    logic [2:0][31:0] p1;
    logic [2:0][31:0] lt;
    logic [2:0] neg;
    logic degen;
  } side_t;

  // Returns the clip flag above the 32-bit clipped value.
  function automatic logic [32:0] sat32(input wide_t v);
    logic [32:0] res;
    if (v > SAT_MAX) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < SAT_MIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/pnsh_front.sv]
// ----------------------------------------------------------------------------
// pnsh_front
// Edge vectors, cross product, magnitude normalization and sum of squares,
// in eight register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pnsh_front import pnsh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic valid_i,
  input  wire logic [2:0][31:0] p1_i,
  input  wire logic [2:0][31:0] p2_i,
  input  wire logic [2:0][31:0] p3_i,
  input  wire logic [2:0][31:0] lt_i,
  output logic valid_o,
  output side_t side_o,
  output logic [2:0][29:0] mg_o,
  output logic [61:0] sum_o
);

  logic [7:0] vld;
  side_t sd [8];

  logic [32:0] ue [3];
  logic [32:0] ve [3];
  logic big_u, big_v;
  logic [31:0] u_next [3];
  logic [31:0] v_next [3];
  logic [31:0] u [3];
  logic [31:0] v [3];

  logic signed [63:0] pr [6];

  logic signed [64:0] c [3];
  logic [64:0] cabs [3];
  logic [63:0] mg3 [3];

  logic [63:0] orv;
  logic [7:0] hit_next;
  logic [2:0] pos_next [8];
  logic [7:0] hit;
  logic [2:0] pos [8];
  logic [63:0] mg4 [3];

  logic [5:0] lead_next;
  logic [5:0] lead;
  logic [63:0] mg5 [3];
  logic [63:0] mgl [3];

  logic [63:0] sh_next [3];
  logic [29:0] mg6 [3];
  logic [59:0] sq [3];
  logic [29:0] mg7 [3];
  logic [29:0] mg8 [3];
  logic [61:0] sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ue[i] = {p2_i[i][31], p2_i[i]} - {p1_i[i][31], p1_i[i]};
      ve[i] = {p3_i[i][31], p3_i[i]} - {p1_i[i][31], p1_i[i]};
    end
    big_u = 1'b0;
    big_v = 1'b0;
    for (int i = 0; i < 3; i++) begin
      big_u = big_u | (ue[i][32] ^ ue[i][31]);
      big_v = big_v | (ve[i][32] ^ ve[i][31]);
    end
    for (int i = 0; i < 3; i++) begin
      u_next[i] = big_u ? ue[i][32:1] : ue[i][31:0];
      v_next[i] = big_v ? ve[i][32:1] : ve[i][31:0];
    end
  end

  always_comb begin
    c[0] = {pr[0][63], pr[0]} - {pr[1][63], pr[1]};
    c[1] = {pr[2][63], pr[2]} - {pr[3][63], pr[3]};
    c[2] = {pr[4][63], pr[4]} - {pr[5][63], pr[5]};
    for (int i = 0; i < 3; i++) begin
      cabs[i] = c[i][64] ? (65'd0 - c[i]) : c[i];
      mg3[i] = cabs[i][63:0];
    end
  end

  always_comb begin
    orv = mg4[0] | mg4[1] | mg4[2];
    for (int g = 0; g < 8; g++) begin
      hit_next[g] = |orv[8*g +: 8];
      pos_next[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orv[8*g + b]) begin
          pos_next[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    lead_next = 6'd0;
    for (int g = 0; g < 8; g++) begin
      if (hit[g]) begin
        lead_next = {3'(g), pos[g]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead >= 6'd29) begin
        sh_next[i] = mgl[i] >> (lead - 6'd29);
      end else begin
        sh_next[i] = mgl[i] << (6'd29 - lead);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0].p1 <= p1_i;
      sd[0].lt <= lt_i;
      sd[0].neg <= '0;
      sd[0].degen <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        u[i] <= u_next[i];
        v[i] <= v_next[i];
      end

      sd[1] <= sd[0];
      pr[0] <= $signed(u[1]) * $signed(v[2]);
      pr[1] <= $signed(v[1]) * $signed(u[2]);
      pr[2] <= $signed(v[0]) * $signed(u[2]);
      pr[3] <= $signed(u[0]) * $signed(v[2]);
      pr[4] <= $signed(u[0]) * $signed(v[1]);
      pr[5] <= $signed(v[0]) * $signed(u[1]);

      sd[2].p1 <= sd[1].p1;
      sd[2].lt <= sd[1].lt;
      sd[2].neg <= {c[2][64], c[1][64], c[0][64]};
      sd[2].degen <= (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
      for (int i = 0; i < 3; i++) begin
        mg4[i] <= mg3[i];
      end

      sd[3] <= sd[2];
      hit <= hit_next;
      for (int g = 0; g < 8; g++) begin
        pos[g] <= pos_next[g];
      end
      for (int i = 0; i < 3; i++) begin
        mg5[i] <= mg4[i];
      end

      sd[4] <= sd[3];
      lead <= lead_next;
      for (int i = 0; i < 3; i++) begin
        mgl[i] <= mg5[i];
      end

      sd[5] <= sd[4];
      for (int i = 0; i < 3; i++) begin
        mg6[i] <= sh_next[i][29:0];
      end

      sd[6] <= sd[5];
      for (int i = 0; i < 3; i++) begin
        sq[i] <= mg6[i] * mg6[i];
        mg7[i] <= mg6[i];
      end

      sd[7] <= sd[6];
      sum <= {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
      for (int i = 0; i < 3; i++) begin
        mg8[i] <= mg7[i];
      end
    end
  end

  assign valid_o = vld[7];
  assign side_o = sd[7];
  assign sum_o = sum;
  assign mg_o = {mg8[2], mg8[1], mg8[0]};

endmodule

`default_nettype wire

[design/pnsh_sqrt.sv]
// ----------------------------------------------------------------------------
// pnsh_sqrt
// Pipelined integer square root, one result bit per register stage, with
// the item's side data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module pnsh_sqrt import pnsh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic valid_i,
  input  wire side_t side_i,
  input  wire logic [2:0][29:0] mg_i,
  input  wire logic [61:0] sum_i,
  output logic valid_o,
  output side_t side_o,
  output logic [2:0][29:0] mg_o,
  output logic [31:0] root_o
);

  logic [63:0] xs [SQRT_STEPS];
  logic [63:0] rs [SQRT_STEPS];
  logic vs [SQRT_STEPS];
  side_t sds [SQRT_STEPS];
  logic [2:0][29:0] mgs [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] x_in;
    logic [63:0] r_in;
    logic v_in;
    side_t s_in;
    logic [2:0][29:0] m_in;
    logic [63:0] trial;

    if (j == 0) begin : g_first
      assign x_in = {2'b0, sum_i};
      assign r_in = '0;
      assign v_in = valid_i;
      assign s_in = side_i;
      assign m_in = mg_i;
    end else begin : g_rest
      assign x_in = xs[j-1];
      assign r_in = rs[j-1];
      assign v_in = vs[j-1];
      assign s_in = sds[j-1];
      assign m_in = mgs[j-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j] <= 1'b0;
      end else if (adv) begin
        vs[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (x_in >= trial) begin
          xs[j] <= x_in - trial;
          rs[j] <= (r_in >> 1) + BIT;
        end else begin
          xs[j] <= x_in;
          rs[j] <= r_in >> 1;
        end
        sds[j] <= s_in;
        mgs[j] <= m_in;
      end
    end
  end

  assign valid_o = vs[SQRT_STEPS-1];
  assign side_o = sds[SQRT_STEPS-1];
  assign mg_o = mgs[SQRT_STEPS-1];
  assign root_o = rs[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

[design/pnsh_div.sv]
// ----------------------------------------------------------------------------
// pnsh_div
// Pipelined restoring divider for one normal component, one quotient bit
// per register stage, rounding to nearest by a half-divisor bias.
// ----------------------------------------------------------------------------
`default_nettype none

module pnsh_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic adv,
  input  wire logic [29:0] mg_i,
  input  wire logic [31:0] mag_i,
  output logic [FRAC_BITS+1:0] q_o
);

  localparam int QB = FRAC_BITS + 2;

  logic [63:0] num;
  logic [63:0] rems [QB];
  logic [31:0] dens [QB];
  logic [QB-1:0] qs [QB];

  assign num = ({34'd0, mg_i} << FRAC_BITS) + {33'd0, mag_i[31:1]};

  for (genvar i = 0; i < QB; i++) begin : g_bit
    localparam int B = QB - 1 - i;
    logic [63:0] rem_in;
    logic [31:0] den_in;
    logic [QB-1:0] q_in;
    logic [63:0] trial;
    logic [QB-1:0] q_set;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = mag_i;
      assign q_in = '0;
    end else begin : g_rest
      assign rem_in = rems[i-1];
      assign den_in = dens[i-1];
      assign q_in = qs[i-1];
    end

    assign trial = {32'd0, den_in} << B;

    always_comb begin
      q_set = q_in;
      q_set[B] = 1'b1;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          rems[i] <= rem_in - trial;
          qs[i] <= q_set;
        end else begin
          rems[i] <= rem_in;
          qs[i] <= q_in;
        end
        dens[i] <= den_in;
      end
    end
  end

  assign q_o = qs[QB-1];

endmodule

`default_nettype wire

[design/pnsh_delay.sv]
// ----------------------------------------------------------------------------
// pnsh_delay
// Delay line that carries valid bits and side data past the divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pnsh_delay #(
  parameter int DEPTH = 18,
  parameter int WIDTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic valid_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        dat[i] <= dat[i-1];
      end
    end
  end

  assign valid_o = vld[DEPTH-1];
  assign data_o = dat[DEPTH-1];

endmodule

`default_nettype wire

[design/pnsh_back.sv]
// ----------------------------------------------------------------------------
// pnsh_back
// Signed normal, plane offset, light dot product and the sixteen matrix
// entries in six register stages, then a column register that sends one
// column word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module pnsh_back import pnsh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_i,
  input  wire side_t side_i,
  input  wire logic [2:0][31:0] q_i,
  input  wire logic out_stall,
  output logic adv,
  output logic out_valid,
  output logic [1:0] column_index,
  output logic signed [31:0] row0_value,
  output logic signed [31:0] row1_value,
  output logic signed [31:0] row2_value,
  output logic signed [31:0] row3_value,
  output logic signed [31:0] plane_a,
  output logic signed [31:0] plane_b,
  output logic signed [31:0] plane_c,
  output logic signed [31:0] plane_d,
  output logic degenerate,
  output logic saturated,
  output logic last_column
);

  localparam wide_t HALF = 68'sd1 <<< (FRAC_BITS - 1);

  logic [5:0] bv;
  logic can_load;

  logic signed [31:0] n_next [3];
  logic signed [31:0] n1 [3];
  logic signed [31:0] p1_1 [3];
  logic signed [31:0] lt1 [3];
  logic dg1;

  logic signed [63:0] pp [3];
  logic signed [63:0] pq [3];
  logic signed [31:0] n2 [3];
  logic signed [31:0] lt2 [3];
  logic dg2;

  wide_t sp, sl;
  logic signed [31:0] n3 [3];
  logic signed [31:0] lt3 [3];
  logic dg3;

  wide_t rp, rl, nd, dotl_next;
  logic [32:0] dres;
  logic signed [31:0] pl4 [4];
  logic signed [31:0] lt4 [3];
  wide_t dotl4;
  logic dsat4;
  logic dg4;

  logic signed [63:0] tm [3][4];
  logic signed [31:0] pl5 [4];
  wide_t dotl5;
  logic dsat5;
  logic dg5;

  logic [32:0] vres [4][4];
  logic [3:0] csat_next;
  logic signed [31:0] rows6 [4][4];
  logic [3:0] csat6;
  logic signed [31:0] pl6 [4];
  logic dg6;

  logic sv;
  logic [1:0] col;
  logic signed [31:0] srow [4][4];
  logic [3:0] scsat;
  logic signed [31:0] spl [4];
  logic sdeg;

  assign can_load = !sv || ((col == LAST_COL) && !out_stall);
  assign adv = !bv[5] || can_load;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_i.degen) begin
        n_next[i] = '0;
      end else if (side_i.neg[i]) begin
        n_next[i] = $signed(32'd0 - q_i[i]);
      end else begin
        n_next[i] = $signed(q_i[i]);
      end
    end
  end

  always_comb begin
    rp = (sp + HALF) >>> FRAC_BITS;
    rl = (sl + HALF) >>> FRAC_BITS;
    nd = '0 - rp;
    dres = sat32(nd);
    dotl_next = rl + WIDE'($signed(dres[31:0]));
  end

  always_comb begin
    wide_t base;
    wide_t term;
    csat_next = {4{dsat5}};
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 4; r++) begin
        base = (r == k) ? dotl5 : '0;
        if (r < 3) begin
          term = (WIDE'(tm[r][k]) + HALF) >>> FRAC_BITS;
        end else begin
          term = WIDE'(pl5[k]);
        end
        vres[k][r] = sat32(base - term);
        csat_next[k] = csat_next[k] | vres[k][r][32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (adv) begin
      bv <= {bv[4:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n1[i] <= n_next[i];
        p1_1[i] <= $signed(side_i.p1[i]);
        lt1[i] <= $signed(side_i.lt[i]);
      end
      dg1 <= side_i.degen;

      for (int i = 0; i < 3; i++) begin
        pp[i] <= n1[i] * p1_1[i];
        pq[i] <= n1[i] * lt1[i];
        n2[i] <= n1[i];
        lt2[i] <= lt1[i];
      end
      dg2 <= dg1;

      sp <= WIDE'(pp[0]) + WIDE'(pp[1]) + WIDE'(pp[2]);
      sl <= WIDE'(pq[0]) + WIDE'(pq[1]) + WIDE'(pq[2]);
      for (int i = 0; i < 3; i++) begin
        n3[i] <= n2[i];
        lt3[i] <= lt2[i];
      end
      dg3 <= dg2;

      for (int i = 0; i < 3; i++) begin
        pl4[i] <= n3[i];
        lt4[i] <= lt3[i];
      end
      pl4[3] <= $signed(dres[31:0]);
      dsat4 <= dres[32];
      dotl4 <= dotl_next;
      dg4 <= dg3;

      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 4; k++) begin
          tm[r][k] <= lt4[r] * pl4[k];
        end
      end
      for (int k = 0; k < 4; k++) begin
        pl5[k] <= pl4[k];
      end
      dotl5 <= dotl4;
      dsat5 <= dsat4;
      dg5 <= dg4;

      for (int k = 0; k < 4; k++) begin
        for (int r = 0; r < 4; r++) begin
          rows6[k][r] <= $signed(vres[k][r][31:0]);
        end
        pl6[k] <= pl5[k];
      end
      csat6 <= csat_next;
      dg6 <= dg5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
      col <= '0;
    end else if (can_load) begin
      sv <= bv[5];
      col <= '0;
    end else if (sv && !out_stall) begin
      col <= col + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && bv[5]) begin
      for (int k = 0; k < 4; k++) begin
        for (int r = 0; r < 4; r++) begin
          srow[k][r] <= rows6[k][r];
        end
        spl[k] <= pl6[k];
      end
      scsat <= csat6;
      sdeg <= dg6;
    end
  end

  assign out_valid = sv;
  assign column_index = col;
  assign row0_value = srow[col][0];
  assign row1_value = srow[col][1];
  assign row2_value = srow[col][2];
  assign row3_value = srow[col][3];
  assign plane_a = spl[0];
  assign plane_b = spl[1];
  assign plane_c = spl[2];
  assign plane_d = spl[3];
  assign degenerate = sdeg;
  assign saturated = scsat[col];
  assign last_column = (col == LAST_COL);

endmodule

`default_nettype wire

[design/planar_shadow_matrix_builder_core.sv]
// An item passes the front stages, square root, dividers and back stages
// into the column register, which sends its first column word; the other
// three follow while out_stall is low. The single port sending the four
// columns sets the item rate; unstalled, the pipeline takes a word a cycle.
// Reset (rst, synchronous) clears all valid bits and the column counter.
// ----------------------------------------------------------------------------
// planar_shadow_matrix_builder_core
// Builds the planar shadow projection matrix from three plane points and a
// light position, in signed fixed point, and sends it column by column.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_shadow_matrix_builder_core import pnsh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [31:0] first_x,
  input  wire logic signed [31:0] first_y,
  input  wire logic signed [31:0] first_z,
  input  wire logic signed [31:0] second_x,
  input  wire logic signed [31:0] second_y,
  input  wire logic signed [31:0] second_z,
  input  wire logic signed [31:0] third_x,
  input  wire logic signed [31:0] third_y,
  input  wire logic signed [31:0] third_z,
  input  wire logic signed [31:0] light_x,
  input  wire logic signed [31:0] light_y,
  input  wire logic signed [31:0] light_z,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] column_index,
  output logic signed [31:0] row0_value,
  output logic signed [31:0] row1_value,
  output logic signed [31:0] row2_value,
  output logic signed [31:0] row3_value,
  output logic signed [31:0] plane_a,
  output logic signed [31:0] plane_b,
  output logic signed [31:0] plane_c,
  output logic signed [31:0] plane_d,
  output logic degenerate,
  output logic saturated,
  output logic last_column
);

  localparam int QB = FRAC_BITS + 2;

  logic adv;

  logic f_valid;
  side_t f_side;
  logic [2:0][29:0] f_mg;
  logic [61:0] f_sum;

  logic s_valid;
  side_t s_side;
  logic [2:0][29:0] s_mg;
  logic [31:0] s_root;

  logic d_valid;
  side_t d_side;
  logic [2:0][31:0] d_q;

  assign in_stall = !adv;

  pnsh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .valid_i (in_valid),
    .p1_i    ({first_z, first_y, first_x}),
    .p2_i    ({second_z, second_y, second_x}),
    .p3_i    ({third_z, third_y, third_x}),
    .lt_i    ({light_z, light_y, light_x}),
    .valid_o (f_valid),
    .side_o  (f_side),
    .mg_o    (f_mg),
    .sum_o   (f_sum)
  );

  pnsh_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .valid_i (f_valid),
    .side_i  (f_side),
    .mg_i    (f_mg),
    .sum_i   (f_sum),
    .valid_o (s_valid),
    .side_o  (s_side),
    .mg_o    (s_mg),
    .root_o  (s_root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [QB-1:0] q;

    pnsh_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .adv   (adv),
      .mg_i  (s_mg[i]),
      .mag_i (s_root),
      .q_o   (q)
    );

    assign d_q[i] = 32'(q);
  end

  pnsh_delay #(
    .DEPTH (QB),
    .WIDTH ($bits(side_t))
  ) u_delay (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .valid_i (s_valid),
    .data_i  (s_side),
    .valid_o (d_valid),
    .data_o  (d_side)
  );

  pnsh_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .valid_i      (d_valid),
    .side_i       (d_side),
    .q_i          (d_q),
    .out_stall    (out_stall),
    .adv          (adv),
    .out_valid    (out_valid),
    .column_index (column_index),
    .row0_value   (row0_value),
    .row1_value   (row1_value),
    .row2_value   (row2_value),
    .row3_value   (row3_value),
    .plane_a      (plane_a),
    .plane_b      (plane_b),
    .plane_c      (plane_c),
    .plane_d      (plane_d),
    .degenerate   (degenerate),
    .saturated    (saturated),
    .last_column  (last_column)
  );

endmodule

`default_nettype wire
